// ===== rtl/mvp_pkg.sv =====
// mvp_pkg: shared types and constants for the matrix vector product block
// no dependencies
package mvp_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_OUT
    } state_t;

    localparam logic CMD_WEIGHT = 1'b0;
    localparam logic CMD_VECTOR = 1'b1;

    localparam int CFG_ROWS = 0;
    localparam int CFG_COLS = 1;

endpackage

// ===== rtl/mvp_mac.sv =====
// mvp_mac: digit-serial signed multiply-accumulate, one bit of b per cycle
// depends on mvp_pkg (none of its items used beyond import)
module mvp_mac
    import mvp_pkg::*;
#(
    parameter int VALUE_BITS = 16,
    parameter int ACC_BITS   = 48
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         start,
    input  logic signed [VALUE_BITS-1:0] a,
    input  logic signed [VALUE_BITS-1:0] b,
    output logic                         busy,
    output logic signed [ACC_BITS-1:0]   acc
);

    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    logic signed [ACC_BITS-1:0]   acc_reg, acc_next;
    logic signed [ACC_BITS-1:0]   mcand_reg, mcand_next;
    logic        [VALUE_BITS-1:0] mplier_reg, mplier_next;
    logic        [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic signed [ACC_BITS-1:0]   addend;

    // shift-add over multiplier bits; msb weight is negative
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        addend      = '0;
        if (clear)
        begin
            acc_next = '0;
        end
        if (start)
        begin
            mcand_next  = ACC_BITS'(a);
            mplier_next = b;
            cnt_next    = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                addend = (cnt_reg == CNT_BITS'(VALUE_BITS - 1)) ? -mcand_reg : mcand_reg;
            end
            acc_next    = acc_reg + addend;
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg + 1'b1;
            if (cnt_reg == CNT_BITS'(VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule

// ===== rtl/matrix_vector_product.sv =====
// matrix_vector_product: top level, stores, sequencer and result register
// depends on mvp_pkg and mvp_mac
//
// usage: input words on cmd/row_index/col_index/value/last_element with
// in_valid/in_ready. cmd 0 stores a weight, cmd 1 stores a vector element;
// a vector word with last_element set starts the product. results leave on
// out_row/dot_value/last_row with out_valid/out_ready, rows 0 upward, the
// final row marked by last_row. store words are taken one per cycle.
// each product term runs through address, memory read, VALUE_BITS shift-add
// steps in the bit-serial multiplier and one step to the next column; the
// multiplier loop sets the rate. no new word is taken while a product runs.
// a stalled receiver holds the result register and stops the sequencer until
// the word is taken. reset clears control state and sets both size registers
// to 16; the weight and vector stores are not cleared. configuration: cfg_we,
// cfg_index, cfg_data, written only while idle; this binds the user, the
// block itself does not enforce it.
module matrix_vector_product
    import mvp_pkg::*;
#(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int VALUE_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [4:0]                   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [3:0]                   row_index,
    input  logic [3:0]                   col_index,
    input  logic signed [VALUE_BITS-1:0] value,
    input  logic                         last_element,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [3:0]                   out_row,
    output logic signed [31:0]           dot_value,
    output logic                         last_row
);

    localparam int RB       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CB       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ACC_BITS = 2 * VALUE_BITS + CB + 1;
    localparam int SAT_BITS = (ACC_BITS > 33) ? ACC_BITS : 33;
    localparam int WDEPTH   = MAX_ROWS * MAX_COLS;
    localparam int WB       = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;

    logic signed [VALUE_BITS-1:0] wmem [WDEPTH];
    logic signed [VALUE_BITS-1:0] vmem [MAX_COLS];

    logic [4:0]    rows_reg, cols_reg;
    state_t        state_reg, state_next;
    logic [RB-1:0] row_reg, row_next;
    logic [CB-1:0] col_reg, col_next;
    logic [RB:0]   nrows;
    logic [CB:0]   ncols;
    logic          rd_pend_reg, rd_pend_next;
    logic          rd_valid_reg;
    logic signed [VALUE_BITS-1:0] w_rd_reg, v_rd_reg;
    logic          mac_start, mac_clear, mac_busy;
    logic signed [ACC_BITS-1:0] acc;
    logic signed [SAT_BITS-1:0] acc_wide;
    logic          ovalid_reg;
    logic [3:0]    orow_reg;
    logic signed [31:0] odot_reg;
    logic          olast_reg;
    logic          take, load_out, row_done_last_col;
    logic signed [31:0] sat;

    assign nrows = (rows_reg == 5'd0) ? (RB+1)'(1) :
                   ({1'b0, rows_reg} > 6'(MAX_ROWS)) ? (RB+1)'(MAX_ROWS) : (RB+1)'(rows_reg);
    assign ncols = (cols_reg == 5'd0) ? (CB+1)'(1) :
                   ({1'b0, cols_reg} > 6'(MAX_COLS)) ? (CB+1)'(MAX_COLS) : (CB+1)'(cols_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= 5'd16;
            cols_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            if (cfg_index == 1'(CFG_ROWS))
                rows_reg <= cfg_data;
            else
                cols_reg <= cfg_data;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;

    // store writes and serial reads
    always_ff @(posedge clk)
    begin
        if (take && cmd == CMD_WEIGHT && 32'(row_index) < MAX_ROWS
            && 32'(col_index) < MAX_COLS)
            wmem[WB'(32'(row_index) * MAX_COLS + 32'(col_index))] <= value;
        if (take && cmd == CMD_VECTOR && 32'(col_index) < MAX_COLS)
            vmem[CB'(col_index)] <= value;
        w_rd_reg <= wmem[WB'(32'(row_reg) * MAX_COLS + 32'(col_reg))];
        v_rd_reg <= vmem[col_reg];
    end

    assign row_done_last_col = ({1'b0, col_reg} + 1'b1 == ncols);

    // sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        rd_pend_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && cmd == CMD_VECTOR && last_element)
                begin
                    state_next   = ST_MAC;
                    row_next     = '0;
                    col_next     = '0;
                    rd_pend_next = 1'b1;
                end
            end
            ST_MAC:
            begin
                if (!rd_pend_reg && !mac_busy && !rd_valid_reg)
                begin
                    if (row_done_last_col)
                        state_next = ST_OUT;
                    else
                    begin
                        col_next     = col_reg + 1'b1;
                        rd_pend_next = 1'b1;
                    end
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    if ({1'b0, row_reg} + 1'b1 == nrows)
                        state_next = ST_IDLE;
                    else
                    begin
                        state_next   = ST_MAC;
                        row_next     = row_reg + 1'b1;
                        col_next     = '0;
                        rd_pend_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        mac_start = 1'b0;
        mac_clear = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                mac_clear = take && cmd == CMD_VECTOR && last_element;
            end
            ST_MAC:
            begin
                mac_start = rd_valid_reg;
            end
            ST_OUT:
            begin
                load_out  = !ovalid_reg || out_ready;
                mac_clear = load_out;
            end
            default:
            begin
                mac_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            rd_pend_reg  <= 1'b0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            rd_pend_reg  <= rd_pend_next;
            rd_valid_reg <= rd_pend_reg;
        end
    end

    mvp_mac #(
        .VALUE_BITS (VALUE_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (mac_clear),
        .start (mac_start),
        .a     (w_rd_reg),
        .b     (v_rd_reg),
        .busy  (mac_busy),
        .acc   (acc)
    );

    assign acc_wide = SAT_BITS'(acc);

    always_comb
    begin
        if (acc_wide > SAT_BITS'(64'sd2147483647))
            sat = 32'sh7fffffff;
        else if (acc_wide < -SAT_BITS'(64'sd2147483648))
            sat = 32'sh80000000;
        else
            sat = 32'(acc_wide);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (load_out)
            ovalid_reg <= 1'b1;
        else if (out_ready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            orow_reg  <= 4'(row_reg);
            odot_reg  <= sat;
            olast_reg <= ({1'b0, row_reg} + 1'b1 == nrows);
        end
    end

    assign out_valid = ovalid_reg;
    assign out_row   = orow_reg;
    assign dot_value = odot_reg;
    assign last_row  = olast_reg;

endmodule
